FILE: hdl/raeu_pkg.sv
// ----------------------------------------------------------------------------
// Register ALU execute unit package
// Shared types and operation codes for the execute unit.
// ----------------------------------------------------------------------------
package raeu_pkg;

  localparam int DataW = 32;
  localparam int IdxW  = 5;

  typedef enum logic [4:0] {
    K_ADD  = 5'd0,  K_SUB  = 5'd1,  K_MUL  = 5'd2,  K_DIV  = 5'd3,
    K_MFHI = 5'd4,  K_MFLO = 5'd5,  K_AND  = 5'd6,  K_OR   = 5'd7,
    K_NOR  = 5'd8,  K_XOR  = 5'd9,  K_SLL  = 5'd10, K_SRL  = 5'd11,
    K_JR   = 5'd12, K_ADDI = 5'd13, K_ANDI = 5'd14, K_ORI  = 5'd15,
    K_XORI = 5'd16
  } kind_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [4:0]  src_a;
    logic [4:0]  src_b;
    logic [4:0]  dest;
    logic [4:0]  shift_amount;
    logic [15:0] immediate;
  } cmd_t;

  typedef struct packed {
    logic             wrote;
    logic [IdxW-1:0]  written_index;
    logic [DataW-1:0] written_value;
    logic [DataW-1:0] jump_target;
    logic             status;
  } res_t;

endpackage

FILE: hdl/register_alu_execute_unit.sv
// ----------------------------------------------------------------------------
// Register ALU execute unit
// Executes one ALU instruction per item against a register file and HI/LO.
// ----------------------------------------------------------------------------
// Usage: raise start with an item on cmd while busy is low; the item is
// accepted at that clock edge and busy rises at once. Sources are read from
// the register file as the item is accepted and the operation is issued in
// the following cycle. Simple operations show their result in the cycle after
// that. Multiply runs a shift-and-add loop and divide a restoring loop of 32
// steps followed by a step that applies the signs; the loop counter bounds
// both loops, and both loops share one 33-bit adder. The result is on res
// while done is high, for exactly one cycle; the receiver cannot hold it off,
// so it must take it then. busy falls in the same cycle that done is shown,
// so a new item may be accepted then.
// Reset clears the register file, HI and LO to zero: the file is held in
// flip-flops with a valid bit per entry, and an entry that is not valid reads
// as zero. Registers at or above REG_COUNT read as zero and writes to them
// are dropped and reported as no write.
// ----------------------------------------------------------------------------
module register_alu_execute_unit
  import raeu_pkg::*;
#(
  parameter int REG_COUNT = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic done,
  output res_t res
);

  localparam int RegIdxW = $clog2(REG_COUNT);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  cmd_t   op;
  logic [DataW-1:0] regs [REG_COUNT];
  logic [REG_COUNT-1:0] valid;
  logic [DataW-1:0] hi, lo;
  logic [DataW-1:0] a, b;
  // Multiply: acc holds the running high half, sh the multiplier / product low.
  // Divide: acc holds the partial remainder, sh the dividend / quotient.
  logic [DataW-1:0] acc, sh, mcand;
  logic [5:0] cnt;
  logic neg_a, neg_b;

  // Shared adder: adds for multiply, subtracts the divisor for divide.
  logic [DataW:0] rem_sh, sum;
  assign rem_sh = {acc, sh[DataW-1]};
  always_comb begin
    if (state == S_MUL) sum = {1'b0, acc} + (sh[0] ? {1'b0, mcand} : '0);
    else sum = rem_sh - {1'b0, mcand};
  end

  logic [DataW-1:0] abs_a, abs_b;
  assign abs_a = a[DataW-1] ? -a : a;
  assign abs_b = b[DataW-1] ? -b : b;

  // Divide sign correction: the quotient is negated when the operand signs
  // differ, and the remainder takes the sign of the dividend.
  logic [DataW-1:0] q_fix, r_fix;
  assign q_fix = (neg_a ^ neg_b) ? -sh : sh;
  assign r_fix = neg_a ? -acc : acc;

  logic [DataW-1:0] wval, simm;
  logic wr;
  logic [4:0] widx;
  assign simm = {{16{op.immediate[15]}}, op.immediate};
  always_comb begin
    wr = 1'b1;
    widx = op.dest;
    wval = '0;
    case (op.kind)
      K_ADD:  wval = a + b;
      K_SUB:  wval = a - b;
      K_MFHI: wval = hi;
      K_MFLO: wval = lo;
      K_AND:  wval = a & b;
      K_OR:   wval = a | b;
      K_NOR:  wval = ~(a | b);
      K_XOR:  wval = a ^ b;
      K_SLL:  wval = b << op.shift_amount;
      K_SRL:  wval = b >> op.shift_amount;
      K_ADDI: begin widx = op.src_b; wval = a + simm; end
      K_ANDI: begin widx = op.src_b; wval = a & {16'd0, op.immediate}; end
      K_ORI:  begin widx = op.src_b; wval = a | {16'd0, op.immediate}; end
      K_XORI: begin widx = op.src_b; wval = a ^ {16'd0, op.immediate}; end
      default: wr = 1'b0;
    endcase
    if (!wr || 32'(widx) >= REG_COUNT) begin
      wr = 1'b0; widx = '0; wval = '0;
    end
  end

  assign busy = (state != S_IDLE) && (state != S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      hi <= '0;
      lo <= '0;
      done <= 1'b0;
    end else begin
      case (state)
        S_IDLE, S_DONE: begin
          done <= 1'b0;
          if (start) begin
            op <= cmd;
            state <= S_READ;
          end else state <= S_IDLE;
        end
        S_READ: begin
          // a and b were loaded on acceptance; issue the operation now.
          cnt <= '0;
          neg_a <= a[DataW-1];
          neg_b <= b[DataW-1];
          if (op.kind == K_MUL) begin
            res <= '0; acc <= '0; sh <= a; mcand <= b;
            done <= 1'b0; state <= S_MUL;
          end else if (op.kind == K_DIV && b != '0) begin
            res <= '0; acc <= '0; sh <= abs_a; mcand <= abs_b;
            done <= 1'b0; state <= S_DIV;
          end else begin
            // A divide by zero lands here with no write and status set.
            res <= {wr, widx, wval, (op.kind == K_JR) ? a : {DataW{1'b0}},
                    op.kind == K_DIV};
            if (wr) begin
              regs[widx[RegIdxW-1:0]] <= wval;
              valid[widx[RegIdxW-1:0]] <= 1'b1;
            end
            done <= 1'b1;
            state <= S_DONE;
          end
        end
        S_MUL: begin
          {acc, sh} <= {sum, sh[DataW-1:1]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DataW-1)) begin
            hi <= sum[DataW:1] - (neg_a ? b : '0) - (neg_b ? a : '0);
            lo <= {sum[0], sh[DataW-1:1]};
            done <= 1'b1;
            state <= S_DONE;
          end else done <= 1'b0;
        end
        S_DIV: begin
          // Steps 0 to 31 develop the magnitudes; at step 32 acc and sh
          // already hold them, so only the signs are applied and the shift
          // made in that cycle is never used.
          if (!sum[DataW]) begin
            acc <= sum[DataW-1:0];
            sh <= {sh[DataW-2:0], 1'b1};
          end else begin
            acc <= rem_sh[DataW-1:0];
            sh <= {sh[DataW-2:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DataW)) begin
            hi <= r_fix; lo <= q_fix; done <= 1'b1; state <= S_DONE;
          end else done <= 1'b0;
        end
        default: begin
          done <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  logic [DataW-1:0] a_rd, b_rd;
  assign a_rd = (32'(cmd.src_a) < REG_COUNT && valid[cmd.src_a[RegIdxW-1:0]]) ?
                regs[cmd.src_a[RegIdxW-1:0]] : '0;
  assign b_rd = (32'(cmd.src_b) < REG_COUNT && valid[cmd.src_b[RegIdxW-1:0]]) ?
                regs[cmd.src_b[RegIdxW-1:0]] : '0;
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a <= a_rd;
      b <= b_rd;
    end
  end

`ifndef ASSERT_OFF
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("done while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted item did not start");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than a cycle");
`endif

endmodule

FILE: tb/register_alu_execute_unit_tb.sv
// ----------------------------------------------------------------------------
// Register ALU execute unit testbench
// Sends a directed set of instructions and then random ones through the
// command port under several idling phases, predicts each result with a
// local model of the register file and HI/LO, and compares field by field.
// ----------------------------------------------------------------------------
module register_alu_execute_unit_tb;
  import raeu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RegCount = 32;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  res_t res;

  register_alu_execute_unit #(.REG_COUNT(RegCount)) dut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .res(res)
  );

  always #5 clk = ~clk;

  // The predictor's own copy of the architectural state.
  logic [31:0] model_regs [RegCount];
  logic [31:0] model_hi;
  logic [31:0] model_lo;

  cmd_t pending_items [$];
  res_t expected_results [$];
  int sender_idle_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;
  bit stimulus_done = 1'b0;

  function automatic logic [31:0] read_model_reg(logic [4:0] idx);
    if (idx < RegCount) begin
      return model_regs[idx];
    end
    return 32'd0;
  endfunction

  // Works out the result of one accepted instruction and updates the state.
  function automatic res_t execute_instruction(cmd_t c);
    res_t r;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] value;
    logic [4:0] widx;
    logic do_write;
    logic signed [63:0] product;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] quo;
    logic [31:0] rem;
    r = '0;
    a = read_model_reg(c.src_a);
    b = read_model_reg(c.src_b);
    value = '0;
    widx = c.dest;
    do_write = 1'b1;
    case (c.kind)
      K_ADD: value = a + b;
      K_SUB: value = a - b;
      K_MUL: begin
        do_write = 1'b0;
        product = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        model_hi = product[63:32];
        model_lo = product[31:0];
      end
      K_DIV: begin
        do_write = 1'b0;
        if (b == 32'd0) begin
          r.status = 1'b1;
        end else begin
          mag_a = a[31] ? -a : a;
          mag_b = b[31] ? -b : b;
          quo = mag_a / mag_b;
          rem = mag_a % mag_b;
          model_lo = (a[31] != b[31]) ? -quo : quo;
          model_hi = a[31] ? -rem : rem;
        end
      end
      K_MFHI: value = model_hi;
      K_MFLO: value = model_lo;
      K_AND: value = a & b;
      K_OR: value = a | b;
      K_NOR: value = ~(a | b);
      K_XOR: value = a ^ b;
      K_SLL: value = b << c.shift_amount;
      K_SRL: value = b >> c.shift_amount;
      K_JR: begin
        do_write = 1'b0;
        r.jump_target = a;
      end
      K_ADDI: begin
        widx = c.src_b;
        value = a + {{16{c.immediate[15]}}, c.immediate};
      end
      K_ANDI: begin
        widx = c.src_b;
        value = a & {16'd0, c.immediate};
      end
      K_ORI: begin
        widx = c.src_b;
        value = a | {16'd0, c.immediate};
      end
      K_XORI: begin
        widx = c.src_b;
        value = a ^ {16'd0, c.immediate};
      end
      default: do_write = 1'b0;
    endcase
    if (do_write && widx < RegCount) begin
      model_regs[widx] = value;
      r.wrote = 1'b1;
      r.written_index = widx;
      r.written_value = value;
    end
    return r;
  endfunction

  // Driver: start is held high while an item waits, and an item is taken
  // from the queue only once the previous one has been accepted, so start
  // never gets two assignments in one step.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_results.push_back(execute_instruction(cmd));
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          cmd <= pending_items.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end else if (!start && pending_items.size() > 0 &&
                   $urandom_range(99) >= sender_idle_pct) begin
        cmd <= pending_items.pop_front();
        start <= 1'b1;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (res.wrote !== want.wrote) begin
          $error("wrote: expected %0h, got %0h", want.wrote, res.wrote);
          fail_count++;
        end
        if (res.written_index !== want.written_index) begin
          $error("written_index: expected %0h, got %0h",
                 want.written_index, res.written_index);
          fail_count++;
        end
        if (res.written_value !== want.written_value) begin
          $error("written_value: expected %0h, got %0h",
                 want.written_value, res.written_value);
          fail_count++;
        end
        if (res.jump_target !== want.jump_target) begin
          $error("jump_target: expected %0h, got %0h",
                 want.jump_target, res.jump_target);
          fail_count++;
        end
        if (res.status !== want.status) begin
          $error("status: expected %0h, got %0h", want.status, res.status);
          fail_count++;
        end
      end
    end
  end

  function automatic cmd_t make_instruction(logic [4:0] kind, logic [4:0] ra,
                                            logic [4:0] rb, logic [4:0] rd,
                                            logic [4:0] sh, logic [15:0] imm);
    cmd_t c;
    c.kind = kind;
    c.src_a = ra;
    c.src_b = rb;
    c.dest = rd;
    c.shift_amount = sh;
    c.immediate = imm;
    return c;
  endfunction

  // Random instruction: mostly valid kinds over a small pool of registers so
  // that values flow between instructions; a few unused kinds as noise.
  function automatic cmd_t random_instruction();
    cmd_t c;
    logic [63:0] raw;
    logic [4:0] pick;
    raw = {$urandom, $urandom};
    c = raw[$bits(cmd_t)-1:0];
    pick = 5'($urandom_range(31));
    if ($urandom_range(99) < 92) begin
      c.kind = 5'($urandom_range(16));
    end else begin
      c.kind = 5'($urandom_range(31, 17));
    end
    if ($urandom_range(3) != 0) begin
      c.src_a = 5'($urandom_range(7));
      c.src_b = 5'($urandom_range(7));
      c.dest = 5'($urandom_range(7));
    end
    if (pick < 3) begin
      c.immediate = pick == 0 ? 16'hFFFF : (pick == 1 ? 16'h8000 : 16'h0000);
    end
    return c;
  endfunction

  task automatic run_phase(int idle_pct, int count);
    sender_idle_pct = idle_pct;
    repeat (count) pending_items.push_back(random_instruction());
    while (pending_items.size() != 0 || start) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < RegCount; i++) model_regs[i] = '0;
    model_hi = '0;
    model_lo = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extreme values, every kind, and the special cases.
    pending_items.push_back(make_instruction(K_DIV, 5'd1, 5'd2, 5'd0, 5'd0, 16'h0)); // by zero
    pending_items.push_back(make_instruction(K_ADDI, 5'd0, 5'd1, 5'd0, 5'd0, 16'h8000));
    pending_items.push_back(make_instruction(K_ADDI, 5'd0, 5'd2, 5'd0, 5'd0, 16'hFFFF));
    pending_items.push_back(make_instruction(K_DIV, 5'd1, 5'd2, 5'd0, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_SLL, 5'd0, 5'd2, 5'd3, 5'd31, 16'h0));
    // Most negative divided by minus one.
    pending_items.push_back(make_instruction(K_DIV, 5'd3, 5'd2, 5'd0, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_MFHI, 5'd0, 5'd0, 5'd4, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_MFLO, 5'd0, 5'd0, 5'd5, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_MUL, 5'd3, 5'd3, 5'd0, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_MFHI, 5'd0, 5'd0, 5'd31, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_MUL, 5'd2, 5'd1, 5'd0, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_MFLO, 5'd0, 5'd0, 5'd6, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_ADD, 5'd3, 5'd3, 5'd7, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_SUB, 5'd0, 5'd3, 5'd8, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_AND, 5'd2, 5'd1, 5'd9, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_OR, 5'd2, 5'd1, 5'd10, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_NOR, 5'd0, 5'd0, 5'd11, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_XOR, 5'd2, 5'd3, 5'd12, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_SRL, 5'd0, 5'd2, 5'd13, 5'd31, 16'h0));
    pending_items.push_back(make_instruction(K_JR, 5'd2, 5'd0, 5'd0, 5'd0, 16'h0));
    pending_items.push_back(make_instruction(K_ANDI, 5'd2, 5'd14, 5'd0, 5'd0, 16'hFFFF));
    pending_items.push_back(make_instruction(K_ORI, 5'd0, 5'd15, 5'd0, 5'd0, 16'hA5A5));
    pending_items.push_back(make_instruction(K_XORI, 5'd2, 5'd0, 5'd0, 5'd0, 16'h5A5A));
    pending_items.push_back(make_instruction(5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 16'hFFFF));
    run_phase(0, 0);

    // Random phases: no idling, mostly idle, partly idle, then no idling.
    run_phase(0, 250);
    run_phase(69, 200);
    run_phase(29, 200);
    run_phase(0, 250);
    stimulus_done = 1'b1;
  end

  // End of run: drain, allow the block's latency, then report.
  initial begin
    wait (stimulus_done);
    while (expected_results.size() != 0 || start) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
